[design/modbus_rtu_response_parser_assert.svh]
// assertion macros for the modbus rtu response parser
`ifndef MODBUS_RTU_RESPONSE_PARSER_ASSERT_SVH
`define MODBUS_RTU_RESPONSE_PARSER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MRTU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define MRTU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/mrtu_pkg.sv]
// shared constants, types and decode function for the modbus rtu response parser
package mrtu_pkg;

	typedef logic [2:0] kind_t;

	localparam kind_t KIND_OTHER = 3'd0;
	localparam kind_t KIND_COILS = 3'd1;
	localparam kind_t KIND_REGS  = 3'd2;
	localparam kind_t KIND_WRITE = 3'd3;
	localparam kind_t KIND_STATE = 3'd4;
	localparam kind_t KIND_EXC   = 3'd5;

	typedef logic [1:0] frame_status_t;

	localparam frame_status_t ST_OK        = 2'd0;
	localparam frame_status_t ST_CRC_SHORT = 2'd1;
	localparam frame_status_t ST_EXC_COUNT = 2'd2;
	localparam frame_status_t ST_TRUNC     = 2'd3;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// crc field tracking codes
	localparam logic [1:0] SEEN_NONE = 2'd0;
	localparam logic [1:0] SEEN_ONE  = 2'd1;
	localparam logic [1:0] SEEN_OK   = 2'd2;
	localparam logic [1:0] SEEN_BAD  = 2'd3;

	localparam int TDATA_W = 40;

	function automatic kind_t kind_of(input logic [7:0] f);
		kind_t k;
		unique case (f)
			8'h01: k = KIND_COILS;
			8'h03, 8'h04: k = KIND_REGS;
			8'h05, 8'h06, 8'h0F, 8'h10: k = KIND_WRITE;
			8'h07: k = KIND_STATE;
			8'h81, 8'h83, 8'h84, 8'h85, 8'h86,
			8'h87, 8'h88, 8'h8F, 8'h90: k = KIND_EXC;
			default: k = KIND_OTHER;
		endcase
		return k;
	endfunction

endpackage

[design/mrtu_crc_byte.sv]
// crc-16 update over one byte, eight bit steps unrolled
module mrtu_crc_byte (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);
	import mrtu_pkg::*;

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

[design/modbus_rtu_response_parser.sv]
// top level of the modbus rtu response parser
// Parses a Modbus RTU response one byte per request on the slave side, with
// tlast on the final byte of the frame. For each accepted byte, the
// frame state (position, address, function, count, running CRC-16
// with init FFFF and reflected polynomial A001) is updated at acceptance and
// the result, if any, lands in a single output register, so a new byte is
// accepted every cycle while the output is empty or being taken. Payload
// bytes (coil data, whole register words, the two value bytes of a write
// echo, the status byte or the exception code) come out with tuser low;
// one status result with tuser high closes each frame and carries address,
// function, value count and frame status (0 ok, 1 crc error or frame
// shorter than four bytes, 2 exception or byte count beyond the frame,
// 3 truncated). Payload of a frame whose status is not ok must be dropped
// downstream. The final byte yields only the status, bytes after the CRC
// field are ignored, and all frame state returns to its reset value after
// each status result.
module modbus_rtu_response_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tlast,   // frame_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [mrtu_pkg::TDATA_W-1:0] m_tdata,
	// [7:0] payload_byte, [15:8] slave_address, [23:16] function_code,
	// [31:24] value_count, [33:32] frame_status, [39:34] zero
	output logic        m_tuser    // is_status
);
	import mrtu_pkg::*;
	`include "modbus_rtu_response_parser_assert.svh"

	// frame state
	logic [8:0]  pos_q;
	logic [15:0] crc_q;
	logic [7:0]  addr_q;
	logic [7:0]  func_q;
	logic [7:0]  count_q;
	logic [8:0]  cs_q;        // position of the first crc byte
	logic [7:0]  crc_lo_q;
	logic [1:0]  seen_q;

	// output register
	logic                out_valid_q;
	logic                out_user_q;
	logic [TDATA_W-1:0]  out_data_q;

	logic s_acc;

	// values as updated by the current byte
	logic [7:0]  b;
	logic [7:0]  addr_e;
	logic [7:0]  func_e;
	logic [7:0]  count_e;
	kind_t       kind_e;
	logic [8:0]  cs_e;
	logic [8:0]  pstart;
	logic [15:0] crc_next;
	logic [1:0]  seen_e;
	logic        crc_lo_wr;
	logic        crc_upd;
	logic [7:0]  vcount;
	frame_status_t status;
	logic        emit_pay;
	logic        has_res;
	logic [TDATA_W-1:0] res_data;

	assign b     = s_tdata;
	assign s_acc = s_tvalid && s_tready;

	// output slot is free or being emptied this cycle
	assign s_tready = !out_valid_q || m_tready;

	mrtu_crc_byte u_crc (
		.crc_in  (crc_q),
		.data    (b),
		.crc_out (crc_next)
	);

	always_comb begin
		addr_e  = (pos_q == 9'd0) ? b : addr_q;
		func_e  = (pos_q == 9'd1) ? b : func_q;
		kind_e  = kind_of(func_e);
		count_e = count_q;
		cs_e    = cs_q;
		if (pos_q == 9'd1) begin
			priority if (kind_e == KIND_WRITE) begin
				cs_e = 9'd6;
			end else if (kind_e == KIND_OTHER) begin
				cs_e = 9'd2;
			end else begin
				cs_e = 9'd3;
			end
		end
		// byte count of the read functions sets where the crc starts
		if (pos_q == 9'd2 && (kind_e == KIND_COILS || kind_e == KIND_REGS)) begin
			count_e = b;
			if (kind_e == KIND_COILS) begin
				cs_e = 9'd3 + {1'b0, b};
			end else begin
				cs_e = 9'd3 + {1'b0, b[7:1], 1'b0};
			end
		end

		crc_upd   = pos_q < cs_e;
		crc_lo_wr = 1'b0;
		seen_e    = seen_q;
		priority if (pos_q < cs_e) begin
			seen_e = seen_q;
		end else if (pos_q == cs_e) begin
			crc_lo_wr = 1'b1;
			seen_e    = SEEN_ONE;
		end else if ({1'b0, pos_q} == {1'b0, cs_e} + 10'd1) begin
			seen_e = (crc_lo_q == crc_q[7:0] && b == crc_q[15:8]) ? SEEN_OK : SEEN_BAD;
		end else begin
			seen_e = seen_q;
		end

		unique case (kind_e)
			KIND_COILS: vcount = count_e;
			KIND_REGS:  vcount = {1'b0, count_e[7:1]};
			KIND_OTHER: vcount = 8'd0;
			default:    vcount = 8'd1;
		endcase

		// status priority: short, count, truncated, crc, exception
		priority if (pos_q < 9'd3) begin
			status = ST_CRC_SHORT;
		end else if ((kind_e == KIND_COILS || kind_e == KIND_REGS) &&
				({1'b0, pos_q} + 10'd1 < {2'b00, count_e})) begin
			status = ST_EXC_COUNT;
		end else if (seen_e == SEEN_NONE || seen_e == SEEN_ONE) begin
			status = ST_TRUNC;
		end else if (seen_e == SEEN_BAD) begin
			status = ST_CRC_SHORT;
		end else if (kind_e == KIND_EXC) begin
			status = ST_EXC_COUNT;
		end else begin
			status = ST_OK;
		end

		unique case (kind_e)
			KIND_WRITE:           pstart = 9'd4;
			KIND_STATE, KIND_EXC: pstart = 9'd2;
			default:              pstart = 9'd3;
		endcase
		emit_pay = (kind_e != KIND_OTHER) && (pos_q >= pstart) && (pos_q < cs_e);

		has_res = s_tlast || emit_pay;
		if (s_tlast) begin
			res_data = {6'd0, status, vcount, func_e, addr_e, 8'h00};
		end else begin
			res_data = {{(TDATA_W-8){1'b0}}, b};
		end
	end

	// frame state, cleared after each status result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 9'd0;
			crc_q    <= CRC_INIT;
			addr_q   <= 8'd0;
			func_q   <= 8'd0;
			count_q  <= 8'd0;
			cs_q     <= 9'd2;
			crc_lo_q <= 8'd0;
			seen_q   <= SEEN_NONE;
		end else if (s_acc) begin
			if (s_tlast) begin
				pos_q    <= 9'd0;
				crc_q    <= CRC_INIT;
				addr_q   <= 8'd0;
				func_q   <= 8'd0;
				count_q  <= 8'd0;
				cs_q     <= 9'd2;
				crc_lo_q <= 8'd0;
				seen_q   <= SEEN_NONE;
			end else begin
				// position saturates on overlong frames
				pos_q   <= (pos_q == 9'h1FF) ? pos_q : pos_q + 9'd1;
				addr_q  <= addr_e;
				func_q  <= func_e;
				count_q <= count_e;
				cs_q    <= cs_e;
				seen_q  <= seen_e;
				if (crc_upd) begin
					crc_q <= crc_next;
				end
				if (crc_lo_wr) begin
					crc_lo_q <= b;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_acc) begin
			out_valid_q <= has_res;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc && has_res) begin
			out_user_q <= s_tlast;
			out_data_q <= res_data;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_user_q;
	assign m_tdata  = out_data_q;

	// frame state is back at its reset value after the last byte
	`MRTU_ASSERT_NEXT(a_frame_clear, s_acc && s_tlast, pos_q == 9'd0 && crc_q == CRC_INIT && seen_q == SEEN_NONE, "frame state not cleared after last byte")
	// the crc field is only tracked once the position has passed its start
	`MRTU_ASSERT_NOW(a_seen_after_start, seen_q != SEEN_NONE, pos_q > cs_q, "crc field seen before its start position")
	// a payload result never carries header or status fields
	`MRTU_ASSERT_NOW(a_payload_clean, m_tvalid && !m_tuser, m_tdata[TDATA_W-1:8] == '0, "payload result with non-zero status fields")

endmodule

[dv/tb_top.sv]
// self-checking testbench for the modbus rtu response parser
module tb_top;
	import mrtu_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int POS_MAX     = 511;
	localparam int DRAIN_WAIT  = 8;

	// function codes of the replies that the testbench builds
	localparam logic [7:0] FC_READ_COILS   = 8'h01;
	localparam logic [7:0] FC_READ_HOLDING = 8'h03;
	localparam logic [7:0] FC_READ_INPUT   = 8'h04;
	localparam logic [7:0] FC_WRITE_COIL   = 8'h05;
	localparam logic [7:0] FC_WRITE_REG    = 8'h06;
	localparam logic [7:0] FC_READ_STATUS  = 8'h07;
	localparam logic [7:0] FC_LOOPBACK     = 8'h08;
	localparam logic [7:0] FC_WRITE_COILS  = 8'h0F;
	localparam logic [7:0] FC_WRITE_REGS   = 8'h10;
	localparam logic [7:0] EXC_FLAG        = 8'h80;

	localparam logic [7:0] FUNC_LIST [0:8] = '{FC_READ_COILS, FC_READ_HOLDING,
		FC_READ_INPUT, FC_WRITE_COIL, FC_WRITE_REG, FC_READ_STATUS, FC_LOOPBACK,
		FC_WRITE_COILS, FC_WRITE_REGS};

	typedef struct {
		logic          is_status;
		logic [7:0]    payload;
		logic [7:0]    address;
		logic [7:0]    func;
		logic [7:0]    count;
		frame_status_t status;
	} parse_out_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic        m_tuser;

	// parser state mirrored in the testbench
	int          frame_pos;
	logic [15:0] crc_acc;
	logic [7:0]  addr_held;
	logic [7:0]  func_held;
	logic [7:0]  count_held;
	int          crc_field_at;
	logic [7:0]  crc_low_rx;
	logic [1:0]  crc_seen;

	parse_out_t  parsed_q [$];
	logic [7:0]  frame_bytes [$];
	int          fail_count    = 0;
	int          cycle_count   = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	modbus_rtu_response_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("modbus_rtu_response_parser regression: fail");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	function automatic kind_t func_kind(input logic [7:0] f);
		case (f)
			FC_READ_COILS: return KIND_COILS;
			FC_READ_HOLDING, FC_READ_INPUT: return KIND_REGS;
			FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS: return KIND_WRITE;
			FC_READ_STATUS: return KIND_STATE;
			EXC_FLAG | FC_READ_COILS, EXC_FLAG | FC_READ_HOLDING, EXC_FLAG | FC_READ_INPUT,
			EXC_FLAG | FC_WRITE_COIL, EXC_FLAG | FC_WRITE_REG, EXC_FLAG | FC_READ_STATUS,
			EXC_FLAG | FC_LOOPBACK, EXC_FLAG | FC_WRITE_COILS,
			EXC_FLAG | FC_WRITE_REGS: return KIND_EXC;
			default: return KIND_OTHER;
		endcase
	endfunction

	// crc-16, reflected, one byte
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	function automatic void clear_frame();
		frame_pos    = 0;
		crc_acc      = CRC_INIT;
		addr_held    = 8'h00;
		func_held    = 8'h00;
		count_held   = 8'h00;
		crc_field_at = 2;
		crc_low_rx   = 8'h00;
		crc_seen     = SEEN_NONE;
	endfunction

	// works out what one accepted byte makes the parser emit
	function automatic void parse_byte(input logic [7:0] b, input logic last);
		int            p;
		int            pay_from;
		int            flen;
		kind_t         k;
		parse_out_t    r;
		frame_status_t st;
		p = frame_pos;
		if (p == 0)
			addr_held = b;
		if (p == 1) begin
			func_held = b;
			k = func_kind(b);
			if (k == KIND_WRITE)
				crc_field_at = 6;
			else if (k == KIND_OTHER)
				crc_field_at = 2;
			else
				crc_field_at = 3;
		end
		k = func_kind(func_held);
		// byte count of a read reply moves the crc field
		if (p == 2 && (k == KIND_COILS || k == KIND_REGS)) begin
			count_held = b;
			crc_field_at = (k == KIND_COILS) ? 3 + int'(b) : 3 + int'(b & 8'hFE);
		end
		if (p < crc_field_at)
			crc_acc = crc_update(crc_acc, b);
		else if (p == crc_field_at) begin
			crc_low_rx = b;
			crc_seen = SEEN_ONE;
		end else if (p == crc_field_at + 1)
			crc_seen = (crc_low_rx == crc_acc[7:0] && b == crc_acc[15:8]) ? SEEN_OK : SEEN_BAD;

		if (last) begin
			flen = p + 1;
			r.is_status = 1'b1;
			r.payload   = 8'h00;
			r.address   = addr_held;
			r.func      = func_held;
			case (k)
				KIND_COILS: r.count = count_held;
				KIND_REGS:  r.count = count_held >> 1;
				KIND_OTHER: r.count = 8'h00;
				default:    r.count = 8'h01;
			endcase
			if (flen < 4)
				st = ST_CRC_SHORT;
			else if ((k == KIND_COILS || k == KIND_REGS) && flen < int'(count_held))
				st = ST_EXC_COUNT;
			else if (crc_seen == SEEN_NONE || crc_seen == SEEN_ONE)
				st = ST_TRUNC;
			else if (crc_seen == SEEN_BAD)
				st = ST_CRC_SHORT;
			else if (k == KIND_EXC)
				st = ST_EXC_COUNT;
			else
				st = ST_OK;
			r.status = st;
			parsed_q.push_back(r);
			clear_frame();
			return;
		end

		frame_pos = (p < POS_MAX) ? p + 1 : POS_MAX;
		if (k == KIND_OTHER)
			return;
		if (k == KIND_WRITE)
			pay_from = 4;
		else if (k == KIND_STATE || k == KIND_EXC)
			pay_from = 2;
		else
			pay_from = 3;
		// payload bytes pass straight through; the last byte of a frame never does
		if (p >= pay_from && p < crc_field_at) begin
			r.is_status = 1'b0;
			r.payload   = b;
			r.address   = 8'h00;
			r.func      = 8'h00;
			r.count     = 8'h00;
			r.status    = ST_OK;
			parsed_q.push_back(r);
		end
	endfunction

	task automatic match_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	// every result request is checked against the oldest prediction
	always @(posedge clk) begin
		parse_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (parsed_q.size() == 0) begin
				$error("unexpected result request, tdata %0h tuser %0b", m_tdata, m_tuser);
				fail_count++;
			end else begin
				want = parsed_q.pop_front();
				match_field("is_status", {7'd0, want.is_status}, {7'd0, m_tuser});
				match_field("payload_byte", want.payload, m_tdata[7:0]);
				match_field("slave_address", want.address, m_tdata[15:8]);
				match_field("function_code", want.func, m_tdata[23:16]);
				match_field("value_count", want.count, m_tdata[31:24]);
				match_field("frame_status", {6'd0, want.status}, {6'd0, m_tdata[33:32]});
				match_field("tdata padding", 8'h00, {2'd0, m_tdata[39:34]});
			end
		end
	end

	// one byte request; tvalid stays up unless a gap is drawn
	task automatic send_rx_byte(input logic [7:0] b, input logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
		parse_byte(b, last);
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i])
			send_rx_byte(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	function automatic void add_crc();
		logic [15:0] c;
		c = CRC_INIT;
		foreach (frame_bytes[i])
			c = crc_update(c, frame_bytes[i]);
		frame_bytes.push_back(c[7:0]);
		frame_bytes.push_back(c[15:8]);
	endfunction

	// well-formed reply with random content
	function automatic void make_reply();
		logic [7:0] fc;
		int         n;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 10)
			fc = 8'($urandom_range(255));
		else if (pick < 30)
			fc = EXC_FLAG | FUNC_LIST[$urandom_range(8)];
		else
			fc = FUNC_LIST[$urandom_range(8)];
		frame_bytes = {};
		frame_bytes.push_back(8'($urandom_range(255)));
		frame_bytes.push_back(fc);
		case (func_kind(fc))
			KIND_COILS, KIND_REGS: begin
				n = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(8);
				frame_bytes.push_back(8'(n));
				// an odd register count carries only whole words
				if (func_kind(fc) == KIND_REGS)
					n = n & 32'hFE;
				repeat (n) frame_bytes.push_back(8'($urandom_range(255)));
			end
			KIND_WRITE:
				repeat (4) frame_bytes.push_back(8'($urandom_range(255)));
			KIND_STATE, KIND_EXC:
				frame_bytes.push_back(8'($urandom_range(255)));
			default: ;
		endcase
		add_crc();
	endfunction

	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// frame shorter than four bytes
		frame_bytes = '{8'h00, FC_LOOPBACK};
		send_frame();
		// loopback, no payload
		frame_bytes = '{8'hFF, FC_LOOPBACK};
		add_crc();
		send_frame();
		// exception reply
		frame_bytes = '{8'h11, EXC_FLAG | FC_READ_HOLDING, 8'h02};
		add_crc();
		send_frame();
		// read coils, one data byte
		frame_bytes = '{8'h01, FC_READ_COILS, 8'h01, 8'hFF};
		add_crc();
		send_frame();
		// write echo, two value bytes come out
		frame_bytes = '{8'h7F, FC_WRITE_REG, 8'h00, 8'h01, 8'hFF, 8'h00};
		add_crc();
		send_frame();
	endtask

	// mostly good replies, the rest broken or noise
	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
		input int byte_budget);
		int sent;
		int pick;
		int bit_no;
		int cut;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < byte_budget) begin
			make_reply();
			pick = $urandom_range(99);
			if (pick < 55) begin
				// left as built
			end else if (pick < 65) begin
				// corrupt one crc bit
				bit_no = $urandom_range(15);
				frame_bytes[frame_bytes.size() - 2 + bit_no / 8] ^= 8'h01 << (bit_no % 8);
			end else if (pick < 75) begin
				// bytes after the crc field
				repeat ($urandom_range(4, 1)) frame_bytes.push_back(8'($urandom_range(255)));
			end else if (pick < 88) begin
				// truncated, possibly mid-payload or before the byte count ends
				cut = $urandom_range(frame_bytes.size() - 1, 1);
				while (frame_bytes.size() > cut)
					void'(frame_bytes.pop_back());
			end else begin
				frame_bytes = {};
				repeat ($urandom_range(12, 1)) frame_bytes.push_back(8'($urandom_range(255)));
			end
			send_frame();
			sent += frame_bytes.size();
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (parsed_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	initial begin
		clear_frame();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_traffic(0, 0, 140);
		test_random_traffic(60, 0, 140);
		test_random_traffic(0, 60, 140);
		test_random_traffic(23, 23, 140);
		wait_drained();
		if (fail_count == 0)
			$display("modbus_rtu_response_parser regression: pass");
		else
			$display("modbus_rtu_response_parser regression: fail");
		$finish;
	end

endmodule
